/* src/i2c_master_register_transfer_macros.svh */
// assertion helpers for the i2c register transfer master
`ifndef I2C_MASTER_REGISTER_TRANSFER_MACROS_SVH
`define I2C_MASTER_REGISTER_TRANSFER_MACROS_SVH
`ifndef SYNTHESIS
`define I2CMRT_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2c master check failed");
`define I2CMRT_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2c master check failed");
`else
`define I2CMRT_ASSERT_SAME(label, clock, rst_n, ante, cons)
`define I2CMRT_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

/* src/i2cmrt_pkg.sv */
package i2cmrt_pkg;

	localparam int BUF_DEPTH_DEF = 16;
	localparam int CFG_DATA_W = 16;

	localparam logic CFG_PHASE_TICKS = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_PUSH = 2'd1;
	localparam logic [1:0] FUNC_LAUNCH = 2'd2;

	localparam logic [2:0] STATUS_OK = 3'd0;
	localparam logic [2:0] STATUS_BUS_BUSY = 3'd1;
	localparam logic [2:0] STATUS_STUCK = 3'd2;
	localparam logic [2:0] STATUS_ADDR_NACK = 3'd3;
	localparam logic [2:0] STATUS_REG_NACK = 3'd4;
	localparam logic [2:0] STATUS_DATA_NACK = 3'd5;

	typedef enum logic [4:0] {
		P_IDLE    = 5'd0,
		P_ST_REL  = 5'd1,
		P_ST_SCLH = 5'd2,
		P_ST_LOW  = 5'd3,
		P_B_SET   = 5'd4,
		P_B_HIGH  = 5'd5,
		P_B_LOW   = 5'd6,
		P_A_SET   = 5'd7,
		P_A_HIGH  = 5'd8,
		P_R_L0    = 5'd9,
		P_R_L1    = 5'd10,
		P_R_H0    = 5'd11,
		P_R_H1    = 5'd12,
		P_M_SET   = 5'd13,
		P_M_HIGH  = 5'd14,
		P_SP_LOW  = 5'd15,
		P_SP_HIGH = 5'd16
	} phase_t;

	typedef enum logic [1:0] {
		K_ADDR_W = 2'd0,
		K_REG    = 2'd1,
		K_DATA   = 2'd2,
		K_ADDR_R = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] func;
		logic       sda_in;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic       direction;
		logic [4:0] byte_count;
		logic [7:0] wr_byte;
	} in_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       rd_valid;
		logic [7:0] rd_byte;
		logic       rd_last;
		logic       busy_res;
		logic       done_res;
		logic [2:0] status;
	} out_t;

	typedef struct packed {
		logic [6:0] dev;
		logic [7:0] rega;
		logic       dir;
	} req_t;

endpackage

/* src/i2c_master_register_transfer.sv */
// I2C master for register transfers. Every request (tick, push of a write byte, launch or
// no-op) gives exactly one result: it is held in the input register, then goes through the
// step logic into the result register, so a new request can enter every cycle unless out_ready
// stalls the result register. Bus timing is counted in tick requests: each bus phase lasts
// phase_ticks ticks (0 counts as 1), and the ACK wait gives up on failed sample ack_timeout + 1
// with a NACK status and one STOP. Write bytes wait in a BUF_DEPTH entry FIFO with a registered
// head read; a write longer than the queued data sends 0x00 for the rest. Configuration writes
// take effect at once and are meant for an idle block.
module i2c_master_register_transfer #(
	parameter int BUF_DEPTH = i2cmrt_pkg::BUF_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  i2cmrt_pkg::in_t                   in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output i2cmrt_pkg::out_t                  out_data,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [i2cmrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	`include "i2c_master_register_transfer_macros.svh"

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int FW = $clog2(BUF_DEPTH + 1);

	// configuration
	logic [15:0] phase_ticks_q;
	logic [7:0]  ack_timeout_q;

	// input stage and result register
	i2cmrt_pkg::in_t  in_s1;
	logic             valid_s1;
	i2cmrt_pkg::out_t out_q;
	logic             out_valid_q;
	logic             advance;
	logic             proc;

	// bus engine state
	i2cmrt_pkg::phase_t phase_q, phase_d;
	i2cmrt_pkg::kind_t  kind_q, kind_d;
	i2cmrt_pkg::req_t   req_q, req_d;
	logic [15:0] delay_q, delay_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bit_q, bit_d;
	logic [4:0]  left_q, left_d;
	logic [7:0]  ackw_q, ackw_d;

	// write fifo
	logic [7:0]    mem [BUF_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q, rptr_d;
	logic [FW-1:0] fill_q;
	logic [7:0]    head_q;
	logic          push, pop;

	// step results
	logic       phase_end;
	logic       rd_valid, rd_last, done;
	logic [7:0] rd_byte;
	logic [2:0] status_code;
	i2cmrt_pkg::out_t res;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign proc      = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cmrt_pkg::PHASE_TICKS_RST;
			ack_timeout_q <= i2cmrt_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cmrt_pkg::CFG_PHASE_TICKS: phase_ticks_q <= cfg_data;
				i2cmrt_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q <= res;
		end
	end

	// fifo storage; the head register follows the read pointer, with a bypass for a
	// byte written to the slot being read
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= in_s1.wr_byte;
		end
		if (push && (wptr_q == rptr_d)) begin
			head_q <= in_s1.wr_byte;
		end else begin
			head_q <= mem[rptr_d];
		end
	end

	always_comb begin
		rptr_d = rptr_q;
		if (pop) begin
			rptr_d = (rptr_q == AW'(BUF_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			rptr_q <= rptr_d;
			if (push) begin
				wptr_q <= (wptr_q == AW'(BUF_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
				fill_q <= fill_q + FW'(1);
			end else if (pop) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cmrt_pkg::P_IDLE;
			kind_q  <= i2cmrt_pkg::K_ADDR_W;
			req_q   <= '0;
			delay_q <= '0;
			shift_q <= '0;
			bit_q   <= '0;
			left_q  <= '0;
			ackw_q  <= '0;
		end else begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			req_q   <= req_d;
			delay_q <= delay_d;
			shift_q <= shift_d;
			bit_q   <= bit_d;
			left_q  <= left_d;
			ackw_q  <= ackw_d;
		end
	end

	// one step of the bus engine
	always_comb begin
		logic [15:0] unit;
		logic [3:0]  bit_n;
		logic [4:0]  left_n;
		logic [7:0]  shift_n;
		logic        sda;
		unit    = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
		bit_n   = bit_q + 4'd1;
		left_n  = (left_q != '0) ? left_q - 5'd1 : left_q;
		sda     = in_s1.sda_in;
		shift_n = {shift_q[6:0], sda};

		phase_d     = phase_q;
		kind_d      = kind_q;
		req_d       = req_q;
		delay_d     = delay_q;
		shift_d     = shift_q;
		bit_d       = bit_q;
		left_d      = left_q;
		ackw_d      = ackw_q;
		push        = 1'b0;
		pop         = 1'b0;
		phase_end   = 1'b0;
		rd_valid    = 1'b0;
		rd_byte     = '0;
		rd_last     = 1'b0;
		done        = 1'b0;
		status_code = i2cmrt_pkg::STATUS_OK;

		if (proc) begin
			case (in_s1.func)
				i2cmrt_pkg::FUNC_PUSH: begin
					push = (fill_q < FW'(BUF_DEPTH));
				end
				i2cmrt_pkg::FUNC_LAUNCH: begin
					if (phase_q == i2cmrt_pkg::P_IDLE) begin
						req_d   = '{dev: in_s1.dev_addr, rega: in_s1.reg_addr,
							dir: in_s1.direction};
						left_d  = in_s1.byte_count;
						kind_d  = i2cmrt_pkg::K_ADDR_W;
						bit_d   = '0;
						ackw_d  = '0;
						delay_d = '0;
						phase_d = i2cmrt_pkg::P_ST_REL;
					end
				end
				i2cmrt_pkg::FUNC_TICK: begin
					if (phase_q != i2cmrt_pkg::P_IDLE) begin
						if (({1'b0, delay_q} + 17'd1) >= {1'b0, unit}) begin
							delay_d   = '0;
							phase_end = 1'b1;
						end else begin
							delay_d = delay_q + 16'd1;
						end
					end
				end
				default: ;
			endcase
		end

		if (phase_end) begin
			case (phase_q)
				i2cmrt_pkg::P_ST_REL, i2cmrt_pkg::P_ST_LOW: begin
					if ((phase_q == i2cmrt_pkg::P_ST_REL) && sda) begin
						phase_d = i2cmrt_pkg::P_ST_SCLH;
					end else if ((phase_q == i2cmrt_pkg::P_ST_LOW) && !sda) begin
						shift_d = {req_q.dev, (kind_q == i2cmrt_pkg::K_ADDR_R)};
						kind_d  = (kind_q == i2cmrt_pkg::K_ADDR_R) ? i2cmrt_pkg::K_ADDR_R
							: i2cmrt_pkg::K_ADDR_W;
						bit_d   = '0;
						phase_d = i2cmrt_pkg::P_B_SET;
					end else begin
						// start condition failed: bus held low or line stuck high
						status_code = (phase_q == i2cmrt_pkg::P_ST_REL)
							? i2cmrt_pkg::STATUS_BUS_BUSY : i2cmrt_pkg::STATUS_STUCK;
						if (kind_q == i2cmrt_pkg::K_ADDR_R) begin
							ackw_d      = {5'd0, status_code};
							phase_d     = i2cmrt_pkg::P_SP_LOW;
							status_code = i2cmrt_pkg::STATUS_OK;
						end else begin
							phase_d = i2cmrt_pkg::P_IDLE;
							delay_d = '0;
							bit_d   = '0;
							left_d  = '0;
							ackw_d  = '0;
							done    = 1'b1;
						end
					end
				end
				i2cmrt_pkg::P_ST_SCLH: phase_d = i2cmrt_pkg::P_ST_LOW;
				i2cmrt_pkg::P_B_SET:   phase_d = i2cmrt_pkg::P_B_HIGH;
				i2cmrt_pkg::P_B_HIGH:  phase_d = i2cmrt_pkg::P_B_LOW;
				i2cmrt_pkg::P_B_LOW: begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_n;
					if (bit_n >= 4'd8) begin
						ackw_d  = '0;
						phase_d = i2cmrt_pkg::P_A_SET;
					end else begin
						phase_d = i2cmrt_pkg::P_B_SET;
					end
				end
				i2cmrt_pkg::P_A_SET: phase_d = i2cmrt_pkg::P_A_HIGH;
				i2cmrt_pkg::P_A_HIGH: begin
					if (!sda) begin
						ackw_d = '0;
						case (kind_q)
							i2cmrt_pkg::K_ADDR_W: begin
								shift_d = req_q.rega;
								kind_d  = i2cmrt_pkg::K_REG;
								bit_d   = '0;
								phase_d = i2cmrt_pkg::P_B_SET;
							end
							i2cmrt_pkg::K_ADDR_R: begin
								if (left_q != '0) begin
									bit_d   = '0;
									shift_d = '0;
									phase_d = i2cmrt_pkg::P_R_L0;
								end else begin
									phase_d = i2cmrt_pkg::P_SP_LOW;
								end
							end
							default: begin
								if ((kind_q == i2cmrt_pkg::K_REG) && req_q.dir) begin
									// read: repeated start, then address with read bit
									kind_d  = i2cmrt_pkg::K_ADDR_R;
									phase_d = i2cmrt_pkg::P_ST_REL;
								end else if (left_q != '0) begin
									// next data byte, zero once the fifo runs dry
									pop     = (fill_q != '0);
									shift_d = (fill_q != '0) ? head_q : 8'd0;
									left_d  = left_q - 5'd1;
									kind_d  = i2cmrt_pkg::K_DATA;
									bit_d   = '0;
									phase_d = i2cmrt_pkg::P_B_SET;
								end else begin
									phase_d = i2cmrt_pkg::P_SP_LOW;
								end
							end
						endcase
					end else if (ackw_q >= ack_timeout_q) begin
						case (kind_q)
							i2cmrt_pkg::K_REG:  ackw_d = {5'd0, i2cmrt_pkg::STATUS_REG_NACK};
							i2cmrt_pkg::K_DATA: ackw_d = {5'd0, i2cmrt_pkg::STATUS_DATA_NACK};
							default:            ackw_d = {5'd0, i2cmrt_pkg::STATUS_ADDR_NACK};
						endcase
						phase_d = i2cmrt_pkg::P_SP_LOW;
					end else begin
						ackw_d = ackw_q + 8'd1;
					end
				end
				i2cmrt_pkg::P_R_L0: phase_d = i2cmrt_pkg::P_R_L1;
				i2cmrt_pkg::P_R_L1: phase_d = i2cmrt_pkg::P_R_H0;
				i2cmrt_pkg::P_R_H0: begin
					shift_d = shift_n;
					bit_d   = bit_n;
					if (bit_n >= 4'd8) begin
						left_d   = left_n;
						rd_valid = 1'b1;
						rd_byte  = shift_n;
						rd_last  = (left_n == '0);
					end
					phase_d = i2cmrt_pkg::P_R_H1;
				end
				i2cmrt_pkg::P_R_H1: begin
					phase_d = (bit_q >= 4'd8) ? i2cmrt_pkg::P_M_SET : i2cmrt_pkg::P_R_L0;
				end
				i2cmrt_pkg::P_M_SET: phase_d = i2cmrt_pkg::P_M_HIGH;
				i2cmrt_pkg::P_M_HIGH: begin
					if (left_q != '0) begin
						bit_d   = '0;
						shift_d = '0;
						phase_d = i2cmrt_pkg::P_R_L0;
					end else begin
						ackw_d  = '0;
						phase_d = i2cmrt_pkg::P_SP_LOW;
					end
				end
				i2cmrt_pkg::P_SP_LOW: phase_d = i2cmrt_pkg::P_SP_HIGH;
				default: begin
					// end of stop, ack_wait carries the final status
					status_code = (phase_q == i2cmrt_pkg::P_SP_HIGH) ? ackw_q[2:0]
						: i2cmrt_pkg::STATUS_OK;
					phase_d = i2cmrt_pkg::P_IDLE;
					delay_d = '0;
					bit_d   = '0;
					left_d  = '0;
					ackw_d  = '0;
					done    = 1'b1;
				end
			endcase
		end
	end

	// bus drive from the state after the step
	always_comb begin
		res           = '0;
		res.scl       = 1'b1;
		res.sda_out   = 1'b1;
		res.sda_drive = 1'b0;
		case (phase_d)
			i2cmrt_pkg::P_ST_REL: begin
				res.scl       = (kind_d != i2cmrt_pkg::K_ADDR_R);
				res.sda_drive = 1'b1;
			end
			i2cmrt_pkg::P_ST_SCLH, i2cmrt_pkg::P_SP_HIGH: begin
				res.sda_drive = 1'b1;
			end
			i2cmrt_pkg::P_ST_LOW: begin
				res.sda_out   = 1'b0;
				res.sda_drive = 1'b1;
			end
			i2cmrt_pkg::P_B_SET, i2cmrt_pkg::P_B_LOW, i2cmrt_pkg::P_B_HIGH: begin
				res.scl       = (phase_d == i2cmrt_pkg::P_B_HIGH);
				res.sda_out   = shift_d[7];
				res.sda_drive = 1'b1;
			end
			i2cmrt_pkg::P_A_SET, i2cmrt_pkg::P_R_L0, i2cmrt_pkg::P_R_L1: begin
				res.scl = 1'b0;
			end
			i2cmrt_pkg::P_M_SET, i2cmrt_pkg::P_M_HIGH: begin
				// nack on the last byte
				res.scl       = (phase_d == i2cmrt_pkg::P_M_HIGH);
				res.sda_out   = (left_d == '0);
				res.sda_drive = 1'b1;
			end
			i2cmrt_pkg::P_SP_LOW: begin
				res.scl       = 1'b0;
				res.sda_out   = 1'b0;
				res.sda_drive = 1'b1;
			end
			default: ;
		endcase
		res.rd_valid = rd_valid;
		res.rd_byte  = rd_byte;
		res.rd_last  = rd_last;
		res.busy_res = (phase_d != i2cmrt_pkg::P_IDLE);
		res.done_res = done;
		res.status   = status_code;
	end

	`I2CMRT_ASSERT_SAME(a_done_not_busy, clk, arst_n, out_valid_q && out_q.done_res, !out_q.busy_res)
	`I2CMRT_ASSERT_SAME(a_rd_on_scl_high, clk, arst_n, out_valid_q && out_q.rd_valid, out_q.scl && !out_q.sda_drive)
	`I2CMRT_ASSERT_SAME(a_idle_clean, clk, arst_n, phase_q == i2cmrt_pkg::P_IDLE, (delay_q == '0) && (bit_q == '0) && (left_q == '0) && (ackw_q == '0))
	`I2CMRT_ASSERT_NEXT(a_launch_starts, clk, arst_n, proc && (in_s1.func == i2cmrt_pkg::FUNC_LAUNCH) && (phase_q == i2cmrt_pkg::P_IDLE), phase_q == i2cmrt_pkg::P_ST_REL)

endmodule

/* verif/i2c_master_register_transfer_tb.sv */
`timescale 1ns / 1ps

module i2c_master_register_transfer_tb;
	import i2cmrt_pkg::*;

	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int unsigned LIMIT_CYCLES = 2000000;

	// how the line answers the master during one transfer
	typedef struct {
		bit    busy_first;
		bit    stuck_first;
		bit    busy_rep;
		bit    stuck_rep;
		bit    nack_on;
		kind_t nack_kind;
		int    ack_flaky;
		int    noise;
	} sda_plan_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// bus model state
	phase_t      bus_ph = P_IDLE;
	logic [15:0] tick_cnt = '0;
	logic [7:0]  shift_reg = '0;
	logic [3:0]  bit_cnt = '0;
	logic [4:0]  bytes_rem = '0;
	logic [7:0]  ack_cnt = '0;
	logic [7:0]  tx_fifo[$];
	req_t        xfer_req = '0;
	kind_t       cur_kind = K_ADDR_W;
	logic [15:0] cfg_unit = PHASE_TICKS_RST;
	logic [7:0]  cfg_tmo = ACK_TIMEOUT_RST;
	out_t        step_evt;

	out_t        bus_view_q[$];
	out_t        bus_want;
	bit          calm = 1'b0;
	int          items_sent = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;

	i2c_master_register_transfer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] phase_len();
		return (cfg_unit == 16'd0) ? 16'd1 : cfg_unit;
	endfunction

	function automatic void xfer_end(input logic [7:0] code);
		bus_ph = P_IDLE;
		tick_cnt = '0;
		bit_cnt = '0;
		bytes_rem = '0;
		ack_cnt = '0;
		step_evt.done_res = 1'b1;
		step_evt.status = code[2:0];
	endfunction

	// status rides in the ack counter while STOP is on the bus
	function automatic void stop_with(input logic [7:0] code);
		ack_cnt = code;
		bus_ph = P_SP_LOW;
	endfunction

	function automatic void tx_load(input logic [7:0] b, input kind_t k);
		shift_reg = b;
		cur_kind = k;
		bit_cnt = '0;
		bus_ph = P_B_SET;
	endfunction

	// an empty queue sends zero bytes
	function automatic void tx_next_data();
		logic [7:0] b;
		b = 8'h00;
		if (tx_fifo.size() > 0)
			b = tx_fifo.pop_front();
		bytes_rem = bytes_rem - 5'd1;
		tx_load(b, K_DATA);
	endfunction

	// a failed repeated START still closes the bus with a STOP
	function automatic void start_abort(input logic [7:0] code);
		if (cur_kind == K_ADDR_R)
			stop_with(code);
		else
			xfer_end(code);
	endfunction

	function automatic void phase_done(input logic sda);
		case (bus_ph)
			P_ST_REL: begin
				if (!sda)
					start_abort(STATUS_BUS_BUSY);
				else
					bus_ph = P_ST_SCLH;
			end
			P_ST_SCLH: bus_ph = P_ST_LOW;
			P_ST_LOW: begin
				if (sda)
					start_abort(STATUS_STUCK);
				else if (cur_kind == K_ADDR_R)
					tx_load({xfer_req.dev, 1'b1}, K_ADDR_R);
				else
					tx_load({xfer_req.dev, 1'b0}, K_ADDR_W);
			end
			P_B_SET: bus_ph = P_B_HIGH;
			P_B_HIGH: bus_ph = P_B_LOW;
			P_B_LOW: begin
				shift_reg = {shift_reg[6:0], 1'b0};
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8) begin
					ack_cnt = '0;
					bus_ph = P_A_SET;
				end else begin
					bus_ph = P_B_SET;
				end
			end
			P_A_SET: bus_ph = P_A_HIGH;
			P_A_HIGH: begin
				if (!sda) begin
					ack_cnt = '0;
					case (cur_kind)
						K_ADDR_W: tx_load(xfer_req.rega, K_REG);
						K_REG: begin
							if (xfer_req.dir) begin
								cur_kind = K_ADDR_R;
								bus_ph = P_ST_REL;
							end else if (bytes_rem > 0) begin
								tx_next_data();
							end else begin
								stop_with(STATUS_OK);
							end
						end
						K_DATA: begin
							if (bytes_rem > 0)
								tx_next_data();
							else
								stop_with(STATUS_OK);
						end
						default: begin
							if (bytes_rem > 0) begin
								bit_cnt = '0;
								shift_reg = '0;
								bus_ph = P_R_L0;
							end else begin
								stop_with(STATUS_OK);
							end
						end
					endcase
				end else if (ack_cnt >= cfg_tmo) begin
					stop_with(cur_kind == K_REG ? STATUS_REG_NACK :
						cur_kind == K_DATA ? STATUS_DATA_NACK : STATUS_ADDR_NACK);
				end else begin
					ack_cnt = ack_cnt + 8'd1;
				end
			end
			P_R_L0: bus_ph = P_R_L1;
			P_R_L1: bus_ph = P_R_H0;
			P_R_H0: begin
				shift_reg = {shift_reg[6:0], sda};
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8) begin
					if (bytes_rem > 0)
						bytes_rem = bytes_rem - 5'd1;
					step_evt.rd_valid = 1'b1;
					step_evt.rd_byte = shift_reg;
					step_evt.rd_last = (bytes_rem == 0);
				end
				bus_ph = P_R_H1;
			end
			P_R_H1: bus_ph = (bit_cnt >= 4'd8) ? P_M_SET : P_R_L0;
			P_M_SET: bus_ph = P_M_HIGH;
			P_M_HIGH: begin
				if (bytes_rem > 0) begin
					bit_cnt = '0;
					shift_reg = '0;
					bus_ph = P_R_L0;
				end else begin
					stop_with(STATUS_OK);
				end
			end
			P_SP_LOW: bus_ph = P_SP_HIGH;
			P_SP_HIGH: xfer_end(ack_cnt);
			default: xfer_end(STATUS_OK);
		endcase
	endfunction

	function automatic out_t bus_step(input in_t r);
		out_t o;
		step_evt = '0;
		case (r.func)
			FUNC_PUSH: begin
				if (tx_fifo.size() < BUF_DEPTH_DEF)
					tx_fifo.push_back(r.wr_byte);
			end
			FUNC_LAUNCH: begin
				if (bus_ph == P_IDLE) begin
					xfer_req.dev = r.dev_addr;
					xfer_req.rega = r.reg_addr;
					xfer_req.dir = r.direction;
					bytes_rem = r.byte_count;
					cur_kind = K_ADDR_W;
					bit_cnt = '0;
					ack_cnt = '0;
					tick_cnt = '0;
					bus_ph = P_ST_REL;
				end
			end
			FUNC_TICK: begin
				if (bus_ph != P_IDLE) begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= phase_len()) begin
						tick_cnt = '0;
						phase_done(r.sda_in);
					end
				end
			end
			default: ;
		endcase

		o = step_evt;
		o.scl = 1'b1;
		o.sda_out = 1'b1;
		o.sda_drive = 1'b0;
		case (bus_ph)
			P_ST_REL: begin
				o.scl = (cur_kind != K_ADDR_R);
				o.sda_drive = 1'b1;
			end
			P_ST_SCLH: o.sda_drive = 1'b1;
			P_ST_LOW: begin
				o.sda_out = 1'b0;
				o.sda_drive = 1'b1;
			end
			P_B_SET, P_B_LOW: begin
				o.scl = 1'b0;
				o.sda_out = shift_reg[7];
				o.sda_drive = 1'b1;
			end
			P_B_HIGH: begin
				o.sda_out = shift_reg[7];
				o.sda_drive = 1'b1;
			end
			P_A_SET, P_R_L0, P_R_L1: o.scl = 1'b0;
			P_M_SET: begin
				o.scl = 1'b0;
				o.sda_out = (bytes_rem == 0);
				o.sda_drive = 1'b1;
			end
			P_M_HIGH: begin
				o.sda_out = (bytes_rem == 0);
				o.sda_drive = 1'b1;
			end
			P_SP_LOW: begin
				o.scl = 1'b0;
				o.sda_out = 1'b0;
				o.sda_drive = 1'b1;
			end
			P_SP_HIGH: o.sda_drive = 1'b1;
			default: ;
		endcase
		o.busy_res = (bus_ph != P_IDLE);
		return o;
	endfunction

	function automatic string fmt_bus(input out_t v);
		return $sformatf("scl=%0b sda_out=%0b drive=%0b rd_valid=%0b rd_byte=%02h rd_last=%0b %s",
			v.scl, v.sda_out, v.sda_drive, v.rd_valid, v.rd_byte, v.rd_last,
			$sformatf("busy=%0b done=%0b status=%0d", v.busy_res, v.done_res, v.status));
	endfunction

	function automatic sda_plan_t good_bus();
		sda_plan_t p;
		p = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, K_ADDR_W, 0, 0};
		return p;
	endfunction

	// sda only counts on the last tick of a phase
	function automatic logic pick_sda(input sda_plan_t p);
		if (tick_cnt + 16'd1 < phase_len())
			return 1'($urandom_range(1));
		case (bus_ph)
			P_ST_REL: return (cur_kind == K_ADDR_R) ? !p.busy_rep : !p.busy_first;
			P_ST_LOW: return (cur_kind == K_ADDR_R) ? p.stuck_rep : p.stuck_first;
			P_A_HIGH: return (p.nack_on && cur_kind == p.nack_kind) ||
				($urandom_range(99) < p.ack_flaky);
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 14);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (bus_view_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %s", fmt_bus(out_data));
			end else begin
				bus_want = bus_view_q.pop_front();
				if (out_data.scl !== bus_want.scl || out_data.sda_out !== bus_want.sda_out ||
					out_data.sda_drive !== bus_want.sda_drive ||
					out_data.rd_valid !== bus_want.rd_valid ||
					out_data.rd_byte !== bus_want.rd_byte ||
					out_data.rd_last !== bus_want.rd_last ||
					out_data.busy_res !== bus_want.busy_res ||
					out_data.done_res !== bus_want.done_res ||
					out_data.status !== bus_want.status) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  expected %s", fmt_bus(bus_want));
						$display("  actual   %s", fmt_bus(out_data));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_req(input in_t r);
		bit ignored;
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		ignored = (r.func == FUNC_TICK && bus_ph == P_IDLE) || r.func == FUNC_NOP ||
			(r.func == FUNC_LAUNCH && bus_ph != P_IDLE);
		if (!ignored)
			items_sent++;
		bus_view_q.push_back(bus_step(r));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (bus_view_q.size() != 0);
	endtask

	// both registers in back-to-back cycles, only with nothing in flight
	task automatic set_config(input logic [15:0] ticks, input logic [7:0] tmo);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PHASE_TICKS;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= {8'h00, tmo};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_unit = ticks;
		cfg_tmo = tmo;
	endtask

	task automatic push_byte(input logic [7:0] b);
		in_t r;
		r = in_t'($urandom);
		r.func = FUNC_PUSH;
		r.wr_byte = b;
		send_req(r);
	endtask

	task automatic run_to_idle(input sda_plan_t p);
		in_t r;
		while (bus_ph != P_IDLE) begin
			r = in_t'($urandom);
			if (p.noise != 0 && $urandom_range(99) < p.noise) begin
				r.func = 2'($urandom_range(3, 1));
			end else begin
				r.func = FUNC_TICK;
				r.sda_in = pick_sda(p);
			end
			send_req(r);
		end
	endtask

	task automatic run_xfer(input int pushes, input logic [6:0] dev, input logic [7:0] rega,
		input logic dir, input logic [4:0] cnt, input sda_plan_t p);
		in_t r;
		repeat (pushes) push_byte(8'($urandom));
		r = in_t'($urandom);
		r.func = FUNC_LAUNCH;
		r.dev_addr = dev;
		r.reg_addr = rega;
		r.direction = dir;
		r.byte_count = cnt;
		send_req(r);
		run_to_idle(p);
	endtask

	task automatic test_write_paths();
		// short queue pads with zero bytes
		push_byte(8'h00);
		push_byte(8'hFF);
		run_xfer(0, 7'h7F, 8'h00, 1'b0, 5'd3, good_bus());
		// zero-length write leaves the queued byte for the next one
		push_byte(8'h5A);
		run_xfer(0, 7'h00, 8'hFF, 1'b0, 5'd0, good_bus());
		run_xfer(0, 7'h2A, 8'h81, 1'b0, 5'd1, good_bus());
	endtask

	task automatic test_read_paths();
		run_xfer(0, 7'h7F, 8'h00, 1'b1, 5'd2, good_bus());
		run_xfer(0, 7'h00, 8'hFF, 1'b1, 5'd0, good_bus());
		run_xfer(0, 7'h15, 8'h3C, 1'b1, 5'd1, good_bus());
	endtask

	task automatic test_start_faults();
		sda_plan_t p;
		p = good_bus();
		p.busy_first = 1'b1;
		run_xfer(0, 7'h11, 8'h22, 1'b0, 5'd1, p);
		p = good_bus();
		p.stuck_first = 1'b1;
		run_xfer(0, 7'h33, 8'h44, 1'b1, 5'd1, p);
		p = good_bus();
		p.busy_rep = 1'b1;
		run_xfer(0, 7'h55, 8'h66, 1'b1, 5'd2, p);
		p = good_bus();
		p.stuck_rep = 1'b1;
		run_xfer(0, 7'h77, 8'h88, 1'b1, 5'd2, p);
	endtask

	task automatic test_ignored_items();
		in_t r;
		r = in_t'($urandom);
		r.func = FUNC_LAUNCH;
		r.direction = 1'b0;
		r.byte_count = 5'd1;
		send_req(r);
		repeat (5) begin
			r = in_t'($urandom);
			r.func = FUNC_TICK;
			r.sda_in = pick_sda(good_bus());
			send_req(r);
		end
		// launch during a transfer must not disturb it
		r = in_t'($urandom);
		r.func = FUNC_LAUNCH;
		send_req(r);
		push_byte(8'hC3);
		r = in_t'($urandom);
		r.func = FUNC_NOP;
		send_req(r);
		run_to_idle(good_bus());
		repeat (3) begin
			r = in_t'($urandom);
			r.func = FUNC_TICK;
			send_req(r);
		end
		r.func = FUNC_NOP;
		send_req(r);
	endtask

	task automatic test_nacks();
		sda_plan_t p;
		p = good_bus();
		p.nack_on = 1'b1;
		set_config(16'd1, 8'd0);
		p.nack_kind = K_ADDR_W;
		run_xfer(0, 7'($urandom), 8'($urandom), 1'b0, 5'd1, p);
		p.nack_kind = K_REG;
		run_xfer(0, 7'($urandom), 8'($urandom), 1'b1, 5'd1, p);
		set_config(16'd1, 8'd3);
		p.nack_kind = K_DATA;
		run_xfer(1, 7'($urandom), 8'($urandom), 1'b0, 5'd2, p);
		set_config(16'd1, 8'd255);
		p.nack_kind = K_ADDR_R;
		run_xfer(0, 7'($urandom), 8'($urandom), 1'b1, 5'd1, p);
		set_config(16'd1, 8'd2);
		p = good_bus();
		p.ack_flaky = 60;
		run_xfer(0, 7'($urandom), 8'($urandom), 1'b0, 5'd2, p);
	endtask

	task automatic test_phase_lengths();
		sda_plan_t p;
		set_config(16'd0, 8'd250);
		run_xfer(1, 7'h6B, 8'h19, 1'b0, 5'd1, good_bus());
		set_config(16'd2, 8'd250);
		run_xfer(0, 7'h4E, 8'hE7, 1'b1, 5'd2, good_bus());
		// long phase: one START phase, then the bus-busy abort
		set_config(16'd200, 8'd1);
		p = good_bus();
		p.busy_first = 1'b1;
		run_xfer(0, 7'h01, 8'h02, 1'b0, 5'd1, p);
	endtask

	task automatic test_random();
		sda_plan_t p;
		in_t r;
		int t;
		int n;
		logic [4:0] cnt;
		items_sent = 0;
		t = 0;
		while (items_sent < 850) begin
			if (t % 6 == 0) begin
				run_to_idle(good_bus());
				case ($urandom_range(4))
					0: set_config(16'($urandom_range(3)), 8'd0);
					1: set_config(16'($urandom_range(3)), 8'd1);
					2: set_config(16'($urandom_range(3)), 8'($urandom_range(8, 2)));
					3: set_config(16'($urandom_range(2)), 8'd250);
					default: set_config(16'd1, 8'd255);
				endcase
			end
			calm = (t >= 12 && t < 20);
			if ($urandom_range(99) < 85) begin
				p = good_bus();
				p.busy_first = ($urandom_range(99) < 3);
				p.stuck_first = ($urandom_range(99) < 3);
				p.busy_rep = ($urandom_range(99) < 3);
				p.stuck_rep = ($urandom_range(99) < 3);
				p.nack_on = ($urandom_range(99) < 10);
				p.nack_kind = kind_t'($urandom_range(3));
				case ($urandom_range(5))
					0: p.ack_flaky = 20;
					1: p.ack_flaky = 50;
					default: p.ack_flaky = 0;
				endcase
				p.noise = 4;
				n = $urandom_range(99);
				if (n < 80)
					cnt = 5'($urandom_range(4));
				else if (n < 95)
					cnt = 5'($urandom_range(16, 5));
				else
					cnt = 5'($urandom_range(31, 17));
				n = ($urandom_range(99) < 80) ? $urandom_range(4) : $urandom_range(18, 8);
				run_xfer(n, 7'($urandom), 8'($urandom), 1'($urandom_range(1)), cnt, p);
			end else begin
				// broken traffic: anything goes
				repeat ($urandom_range(30, 5)) begin
					r = in_t'($urandom);
					send_req(r);
				end
			end
			t++;
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_write_paths();
		test_read_paths();
		test_start_faults();
		test_ignored_items();
		test_nacks();
		test_phase_lengths();
		test_random();
		wait_drained();
		repeat (4) @(posedge clk);
		if (errors == 0 && bus_view_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
